### sv/bfa_pkg.sv
// shared types and constants of the best-fit block allocator
package bfa_pkg;

	localparam int FREE_ENTRIES = 64;
	localparam int MAX_REGIONS  = 16;
	localparam int REGION_BYTES = 4096;
	localparam int HEADER_BYTES = 16;

	localparam int IDX_W   = $clog2(FREE_ENTRIES);
	localparam int ADDR_W  = 16;
	localparam int SIZE_W  = 12;
	localparam int REQ_W   = SIZE_W + 1;
	localparam int STAMP_W = 32;
	localparam int REG_W   = 5;
	localparam int HS_DEPTH = 8192;
	localparam int HS_AW    = $clog2(HS_DEPTH);
	localparam int REGION_SHIFT = $clog2(REGION_BYTES);
	localparam int FRESH_SIZE   = REGION_BYTES - HEADER_BYTES;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_REGION  = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0]  hdr;
		logic [SIZE_W-1:0]  size;
		logic [STAMP_W-1:0] stamp;
	} ent_t;

	typedef struct packed {
		logic             we;
		logic             clr;
		logic [IDX_W-1:0] idx;
		ent_t             ent;
	} tbl_wr_t;

	typedef struct packed {
		logic              we;
		logic [HS_AW-1:0]  addr;
		logic [SIZE_W-1:0] wdata;
	} hs_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_FREE_RD,
		S_ALLOC,
		S_HDR2,
		S_DONE
	} state_t;

endpackage

### sv/bfa_cfg.sv
// apb register file holding the region limit
module bfa_cfg
	import bfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [0:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [REG_W-1:0] region_limit
);

	logic [REG_W-1:0] limit_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= REG_W'(16);
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			limit_q <= pwdata[REG_W-1:0];
		end
	end

	assign pready       = 1'b1;
	assign prdata       = (paddr == 1'b0) ? {{(32-REG_W){1'b0}}, limit_q} : 32'd0;
	assign region_limit = limit_q;

endmodule

### sv/bfa_extent_table.sv
// free extent table: entry memory plus per-entry valid flags
module bfa_extent_table
	import bfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output ent_t             rd_ent,
	output logic             rd_valid,
	input  tbl_wr_t          wr
);

	ent_t                    mem [FREE_ENTRIES];
	logic [FREE_ENTRIES-1:0] valid_q;

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx] <= wr.ent;
		end
		rd_ent <= mem[rd_idx];
	end

	// valid flags, read alongside the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr.idx] <= 1'b1;
			end else if (wr.clr) begin
				valid_q[wr.idx] <= 1'b0;
			end
			rd_valid <= valid_q[rd_idx];
		end
	end

endmodule

### sv/bfa_header_store.sv
// header size store, single port synchronous memory
module bfa_header_store
	import bfa_pkg::*;
(
	input  logic              clk,
	input  hs_req_t           req,
	output logic [SIZE_W-1:0] rdata
);

	logic [SIZE_W-1:0] mem [HS_DEPTH];

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

### sv/best_fit_block_allocator_unit.sv
// Best-fit block allocator: one transaction in, one result out, one item at a time.
// An oversized allocate goes from idle straight to the result state; any other item runs a scan
// that reads each of the 64 free-table entries once, a decide state, then up to two header
// store accesses and the result state. The next transaction is taken in the cycle after the
// result is registered; a stalled result holds the block for the stall.
// Reset clears the valid flags, insertion counter, region count and control state;
// the region limit returns to 16. No clearing pass is needed.
module best_fit_block_allocator_unit
	import bfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] granted_address,
	output logic [1:0]        status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [0:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	state_t state_q, state_d;

	logic [REG_W-1:0] region_limit;
	logic [REG_W-1:0] regions_q;
	logic [STAMP_W-1:0] counter_q;

	logic              op_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] free_hdr_q;
	logic [IDX_W:0]    idx_q;
	logic              issue_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              best_found_q, empty_found_q;
	logic [IDX_W-1:0]  best_idx_q, empty_idx_q;
	logic [SIZE_W-1:0] best_size_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [ADDR_W-1:0] best_hdr_q;

	logic [IDX_W-1:0]  slot_q;
	logic [ADDR_W-1:0] chosen_hdr_q;
	logic [SIZE_W-1:0] chosen_size_q;
	logic [SIZE_W-1:0] rest_size_q;
	logic [ADDR_W-1:0] rest_hdr_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] granted_q;
	logic [1:0]        status_q, result_status_q;
	logic [ADDR_W-1:0] result_addr_q;

	ent_t              rd_ent;
	logic              rd_valid;
	tbl_wr_t           tbl_wr;
	hs_req_t           hs_req;
	logic [SIZE_W-1:0] hs_rdata;

	logic [REQ_W-1:0]  req_round;
	logic              in_accept, out_free;
	logic [REG_W-1:0]  lim;
	logic              can_open;
	logic              fits, better;
	logic [REQ_W-1:0]  rem;
	logic              keep_rest;
	logic [ADDR_W-1:0] payload;
	logic [ADDR_W-1:0] region_base;

	bfa_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.region_limit(region_limit)
	);

	bfa_extent_table u_table (
		.clk(clk), .arst_n(arst_n), .rd_idx(idx_q[IDX_W-1:0]),
		.rd_ent(rd_ent), .rd_valid(rd_valid), .wr(tbl_wr)
	);

	bfa_header_store u_hdr (
		.clk(clk), .req(hs_req), .rdata(hs_rdata)
	);

	// handshake and request preparation
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign req_round = ({1'b0, request_size} + REQ_W'(7)) & ~REQ_W'(7);

	// effective limit and region base
	assign lim = (region_limit < REG_W'(MAX_REGIONS)) ? region_limit : REG_W'(MAX_REGIONS);
	assign can_open    = regions_q < lim;
	assign region_base = ADDR_W'(regions_q) << REGION_SHIFT;

	// compare of the entry arriving from the table
	assign fits   = rd_valid && ({1'b0, rd_ent.size} >= req_q);
	assign better = !best_found_q || (rd_ent.size < best_size_q) ||
		(rd_ent.size == best_size_q && rd_ent.stamp > best_stamp_q);

	// split arithmetic of the chosen extent
	assign rem       = {1'b0, chosen_size_q} - req_q;
	assign keep_rest = rem > REQ_W'(HEADER_BYTES);
	assign payload   = chosen_hdr_q + ADDR_W'(HEADER_BYTES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (op == OP_ALLOC && req_round > REQ_W'(FRESH_SIZE)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (idx_q[IDX_W]) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (op_q == OP_FREE) begin
					state_d = empty_found_q ? S_FREE_RD : S_DONE;
				end else if (best_found_q || (can_open && empty_found_q)) begin
					state_d = S_ALLOC;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FREE_RD: state_d = S_DONE;
			S_ALLOC:   state_d = keep_rest ? S_HDR2 : S_DONE;
			S_HDR2:    state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		tbl_wr           = '0;
		tbl_wr.idx       = slot_q;
		hs_req           = '0;
		hs_req.addr      = free_hdr_q[ADDR_W-1:3];
		case (state_q)
			S_FREE_RD: begin
				tbl_wr.we        = 1'b1;
				tbl_wr.ent.hdr   = free_hdr_q;
				tbl_wr.ent.size  = hs_rdata;
				tbl_wr.ent.stamp = counter_q;
			end
			S_ALLOC: begin
				hs_req.we    = 1'b1;
				hs_req.addr  = chosen_hdr_q[ADDR_W-1:3];
				hs_req.wdata = req_q[SIZE_W-1:0];
				if (keep_rest) begin
					tbl_wr.we        = 1'b1;
					tbl_wr.ent.hdr   = payload + ADDR_W'(req_q);
					tbl_wr.ent.size  = SIZE_W'(rem - REQ_W'(HEADER_BYTES));
					tbl_wr.ent.stamp = counter_q;
				end else begin
					tbl_wr.clr = 1'b1;
				end
			end
			S_HDR2: begin
				hs_req.we    = 1'b1;
				hs_req.addr  = rest_hdr_q[ADDR_W-1:3];
				hs_req.wdata = rest_size_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			regions_q   <= '0;
			counter_q   <= '0;
			idx_q       <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= (state_q == S_SCAN) && !idx_q[IDX_W];
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN && !idx_q[IDX_W]) begin
				idx_q <= idx_q + 1'b1;
			end
			// region open consumes one stamp
			if (state_q == S_DECIDE && op_q == OP_ALLOC && !best_found_q &&
				can_open && empty_found_q) begin
				regions_q <= regions_q + 1'b1;
				counter_q <= counter_q + 1'b1;
			end else if (state_q == S_FREE_RD || (state_q == S_ALLOC && keep_rest)) begin
				counter_q <= counter_q + 1'b1;
			end
			// result register
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q            <= op;
			req_q           <= req_round;
			free_hdr_q      <= payload_address - ADDR_W'(HEADER_BYTES);
			result_addr_q   <= '0;
			result_status_q <= (op == OP_ALLOC && req_round > REQ_W'(FRESH_SIZE)) ?
				ST_NO_REGION : ST_OK;
			best_found_q    <= 1'b0;
			empty_found_q   <= 1'b0;
		end
		idx_s1 <= idx_q[IDX_W-1:0];
		// scan: best fit and lowest empty entry
		if (issue_s1) begin
			if (!rd_valid && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= idx_s1;
			end
			if (fits && better) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s1;
				best_size_q  <= rd_ent.size;
				best_stamp_q <= rd_ent.stamp;
				best_hdr_q   <= rd_ent.hdr;
			end
		end
		// choose the extent or report failure
		if (state_q == S_DECIDE) begin
			if (op_q == OP_FREE) begin
				slot_q <= empty_idx_q;
				if (!empty_found_q) begin
					result_status_q <= ST_TABLE_FULL;
				end
			end else if (best_found_q) begin
				slot_q        <= best_idx_q;
				chosen_hdr_q  <= best_hdr_q;
				chosen_size_q <= best_size_q;
			end else if (!can_open) begin
				result_status_q <= ST_NO_REGION;
			end else if (!empty_found_q) begin
				result_status_q <= ST_TABLE_FULL;
			end else begin
				slot_q        <= empty_idx_q;
				chosen_hdr_q  <= region_base;
				chosen_size_q <= SIZE_W'(FRESH_SIZE);
			end
		end
		if (state_q == S_ALLOC) begin
			result_addr_q <= payload;
			rest_hdr_q    <= payload + ADDR_W'(req_q);
			rest_size_q   <= SIZE_W'(rem - REQ_W'(HEADER_BYTES));
		end
		if (state_q == S_DONE && out_free) begin
			granted_q <= result_addr_q;
			status_q  <= result_status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = granted_q;
	assign status          = status_q;

endmodule

### dv/best_fit_block_allocator_unit_checker.sv
// transaction monitor, allocator predictor and result scoreboard
module best_fit_block_allocator_unit_checker
	import bfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              op,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [ADDR_W-1:0] granted_address,
	input  logic [1:0]        status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [0:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        st;
	} grant_t;

	localparam logic [0:0] ADDR_REGION_LIMIT = 1'b0;

	// free extent table and header store of the predictor
	logic              ext_used  [FREE_ENTRIES];
	logic [ADDR_W-1:0] ext_hdr   [FREE_ENTRIES];
	logic [SIZE_W-1:0] ext_size  [FREE_ENTRIES];
	logic [STAMP_W-1:0] ext_stamp [FREE_ENTRIES];
	logic [SIZE_W-1:0] hdr_sizes [HS_DEPTH];
	logic [STAMP_W-1:0] list_count;
	logic [REG_W-1:0]  open_regions;
	logic [REG_W-1:0]  limit_reg;
	grant_t            pending_grants[$];
	int                errs;

	function automatic int first_empty();
		for (int i = 0; i < FREE_ENTRIES; i++)
			if (!ext_used[i])
				return i;
		return -1;
	endfunction

	function automatic void list_free(int slot, logic [ADDR_W-1:0] hdr, logic [SIZE_W-1:0] sz);
		ext_used[slot] = 1'b1;
		ext_hdr[slot] = hdr;
		ext_size[slot] = sz;
		ext_stamp[slot] = list_count;
		list_count = list_count + 1;
		hdr_sizes[hdr[ADDR_W-1:3]] = sz;
	endfunction

	function automatic int smallest_fit(logic [REQ_W-1:0] req);
		int b;
		b = -1;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (!ext_used[i] || {1'b0, ext_size[i]} < req)
				continue;
			if (b < 0 || ext_size[i] < ext_size[b] ||
				(ext_size[i] == ext_size[b] && ext_stamp[i] > ext_stamp[b]))
				b = i;
		end
		return b;
	endfunction

	function automatic grant_t allocate_or_free(logic o, logic [SIZE_W-1:0] rs,
		logic [ADDR_W-1:0] pa);
		grant_t g;
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] hdr;
		logic [ADDR_W-1:0] pay;
		int b, s, lim, rem;
		g.addr = '0;
		g.st = ST_OK;
		if (o == OP_ALLOC) begin
			req = ({1'b0, rs} + 13'd7) & ~13'd7;
			if (req > FRESH_SIZE) begin
				g.st = ST_NO_REGION;
			end else begin
				b = smallest_fit(req);
				if (b < 0) begin
					lim = (limit_reg < MAX_REGIONS) ? limit_reg : MAX_REGIONS;
					s = first_empty();
					if (open_regions >= lim) begin
						g.st = ST_NO_REGION;
					end else if (s < 0) begin
						g.st = ST_TABLE_FULL;
					end else begin
						list_free(s, ADDR_W'(open_regions * REGION_BYTES), SIZE_W'(FRESH_SIZE));
						open_regions = open_regions + 1'b1;
						b = s;
					end
				end
				if (b >= 0) begin
					hdr = ext_hdr[b];
					pay = hdr + ADDR_W'(HEADER_BYTES);
					rem = int'(ext_size[b]) - int'(req);
					ext_used[b] = 1'b0;
					hdr_sizes[hdr[ADDR_W-1:3]] = req[SIZE_W-1:0];
					if (rem > HEADER_BYTES)
						list_free(b, pay + ADDR_W'(req), SIZE_W'(rem - HEADER_BYTES));
					g.addr = pay;
				end
			end
		end else begin
			hdr = pa - ADDR_W'(HEADER_BYTES);
			s = first_empty();
			if (s < 0)
				g.st = ST_TABLE_FULL;
			else
				list_free(s, hdr, hdr_sizes[hdr[ADDR_W-1:3]]);
		end
		return g;
	endfunction

	// follow register writes, predict accepted items, compare results
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			for (int i = 0; i < FREE_ENTRIES; i++)
				ext_used[i] = 1'b0;
			list_count = '0;
			open_regions = '0;
			limit_reg = REG_W'(16);
			pending_grants.delete();
			errs = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_REGION_LIMIT)
				limit_reg = pwdata[REG_W-1:0];
			if (out_valid && !out_stall) begin
				if (pending_grants.size() == 0) begin
					$error("result with no transaction pending: granted_address %h status %0d",
						granted_address, status);
					errs++;
				end else begin
					want = pending_grants.pop_front();
					if (granted_address !== want.addr) begin
						$error("granted_address expected %h actual %h", want.addr,
							granted_address);
						errs++;
					end
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_grants.push_back(allocate_or_free(op, request_size, payload_address));
		end
		fail_count <= errs + pending_grants.size();
	end

endmodule

### dv/best_fit_block_allocator_unit_test.sv
// stimulus and verdict for the best-fit block allocator
module best_fit_block_allocator_unit_test
	import bfa_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] payload_address;
	logic              out_valid;
	logic              out_stall;
	logic [ADDR_W-1:0] granted_address;
	logic [1:0]        status;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [0:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count;

	localparam logic [0:0] ADDR_REGION_LIMIT = 1'b0;

	int                sent;
	int                got;
	logic [ADDR_W-1:0] granted_pool[$];

	best_fit_block_allocator_unit u_dut (.*);

	best_fit_block_allocator_unit_checker u_chk (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// collect granted payloads so frees only hit written headers
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got++;
			if (status == ST_OK && granted_address != '0)
				granted_pool.push_back(granted_address);
		end
	end

	// result side: random stall pattern, stall-free phases and one long hold-off
	initial begin
		int held;
		held = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 600) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
				out_stall <= 1'b0;
			end else if ((sent / 150) % 3 == 1) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	task automatic reg_write(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_REGION_LIMIT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop offering, then wait until every transaction has its result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (got != sent)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// offer one transaction; valid stays high into the next one unless a gap follows
	task automatic offer(logic o, logic [SIZE_W-1:0] rs, logic [ADDR_W-1:0] pa, int gap);
		in_valid <= 1'b1;
		op <= o;
		request_size <= rs;
		payload_address <= pa;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			op <= 1'($urandom);
			request_size <= SIZE_W'($urandom);
			payload_address <= ADDR_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic free_recent();
		wait_drained();
		if (granted_pool.size() > 0)
			offer(OP_FREE, SIZE_W'($urandom), granted_pool[granted_pool.size() - 1], 1);
	endtask

	task automatic random_items(int n);
		int burst;
		logic [SIZE_W-1:0] rs;
		burst = $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: rs = SIZE_W'($urandom);
				1: rs = SIZE_W'($urandom_range(1000, 4095));
				default: rs = SIZE_W'($urandom_range(0, 300));
			endcase
			burst--;
			if (granted_pool.size() > 0 && $urandom_range(0, 1))
				offer(OP_FREE, rs,
					granted_pool[$urandom_range(0, granted_pool.size() - 1)],
					burst == 0 ? $urandom_range(1, 90) : 0);
			else
				offer(OP_ALLOC, rs, ADDR_W'($urandom),
					burst == 0 ? $urandom_range(1, 90) : 0);
			if (burst == 0)
				burst = $urandom_range(1, 12);
		end
	endtask

	// stimulus
	initial begin
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		request_size = '0;
		payload_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_REGION_LIMIT;
		pwdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowest limit: one region, then exhaustion and oversized requests
		reg_write(32'd1);
		offer(OP_ALLOC, 12'd8, 16'hffff, 0);
		offer(OP_ALLOC, 12'd0, 16'h0000, 0);
		offer(OP_ALLOC, 12'd7, 16'h0000, 2);
		offer(OP_ALLOC, 12'd4081, 16'h0000, 0);
		offer(OP_ALLOC, 12'd4095, 16'h0000, 0);
		offer(OP_ALLOC, 12'd4080, 16'h0000, 0);
		offer(OP_ALLOC, 12'd64, 16'h0000, 0);
		offer(OP_ALLOC, 12'd64, 16'h0000, 3);
		free_recent();
		offer(OP_ALLOC, 12'd64, 16'h0000, 0);
		offer(OP_ALLOC, 12'd3000, 16'h0000, 0);
		offer(OP_ALLOC, 12'd900, 16'h0000, 0);
		free_recent();
		free_recent();
		offer(OP_ALLOC, 12'd56, 16'h0000, 0);
		offer(OP_ALLOC, 12'd4000, 16'h0000, 0);
		random_items(100);
		wait_drained();

		// a few regions
		reg_write(32'd3);
		offer(OP_ALLOC, 12'd4080, 16'h0000, 0);
		offer(OP_ALLOC, 12'd4000, 16'h0000, 0);
		random_items(300);
		wait_drained();

		// above the hardware maximum
		reg_write(32'd31);
		random_items(500);
		wait_drained();

		// full maximum, then back to a lower limit
		reg_write(32'd16);
		random_items(250);
		wait_drained();
		reg_write(32'd8);
		random_items(280);

		in_valid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
